>>> rtl/cue_sheet_file_reference_parser_defines.svh
// Assertion helpers shared by csfrp_parse and csfrp_out_fifo.
`ifndef CUE_SHEET_FILE_REFERENCE_PARSER_DEFINES_SVH
`define CUE_SHEET_FILE_REFERENCE_PARSER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, held off during reset.
`define CSFRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csfrp: implication check failed");

// Next-cycle implication, checked on clk_i, held off during reset.
`define CSFRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csfrp: next-cycle check failed");

`endif

>>> rtl/csfrp_pkg.sv
package csfrp_pkg;

  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrQuote = 8'h22;

  localparam int unsigned FifoDepth = 3;

  typedef enum logic [2:0] {
    MODE_LEAD     = 3'd0,
    MODE_KEYWORD  = 3'd1,
    MODE_GAP      = 3'd2,
    MODE_UNQUOTED = 3'd3,
    MODE_QUOTED   = 3'd4,
    MODE_SKIP     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] name_byte;
    logic       run_end;
  } result_t;

  // Results caused by one input word: count (0..2), first and second entry.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } res_pair_t;

  function automatic logic [7:0] keyword_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h46;  // F
      2'd1:    c = 8'h49;  // I
      2'd2:    c = 8'h4C;  // L
      default: c = 8'h45;  // E
    endcase
    return c;
  endfunction

endpackage

>>> rtl/csfrp_parse.sv
`include "cue_sheet_file_reference_parser_defines.svh"

module csfrp_parse
  import csfrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output res_pair_t  res_o
);

  mode_e      mode_q, mode_d;
  logic [1:0] kw_idx_q, kw_idx_d;
  logic       started_q, started_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LEAD;
      kw_idx_q  <= 2'd0;
      started_q <= 1'b0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      kw_idx_q  <= kw_idx_d;
      started_q <= started_d;
    end
  end

  logic  is_blank;
  logic  step_emit;
  kind_e step_kind;
  logic  end_emit;
  kind_e end_kind;
  mode_e mode_n;

  assign is_blank = (byte_i == ChrSpace) || (byte_i == ChrTab);

  always_comb begin
    mode_n    = mode_q;
    kw_idx_d  = kw_idx_q;
    started_d = started_q;
    step_emit = 1'b0;
    step_kind = KIND_BYTE;
    end_emit  = 1'b0;
    end_kind  = KIND_COMMIT;

    if (byte_i == ChrLf) begin
      mode_n = MODE_LEAD;
    end else begin
      unique case (mode_q)
        MODE_LEAD: begin
          if (is_blank || byte_i == ChrCr) begin
            mode_n = MODE_LEAD;
          end else if (byte_i == keyword_char(2'd0)) begin
            mode_n   = MODE_KEYWORD;
            kw_idx_d = 2'd1;
          end else begin
            mode_n = MODE_SKIP;
          end
        end
        MODE_KEYWORD: begin
          if (byte_i == keyword_char(kw_idx_q)) begin
            if (kw_idx_q == 2'd3) begin
              mode_n   = MODE_GAP;
              kw_idx_d = 2'd0;
            end else begin
              kw_idx_d = kw_idx_q + 2'd1;
            end
          end else begin
            mode_n   = MODE_SKIP;
            kw_idx_d = 2'd0;
          end
        end
        MODE_GAP: begin
          if (is_blank) begin
            mode_n = MODE_GAP;
          end else if (byte_i == ChrQuote) begin
            mode_n    = MODE_QUOTED;
            started_d = 1'b0;
          end else if (byte_i == ChrCr) begin
            mode_n = MODE_SKIP;
          end else begin
            step_emit = 1'b1;
            mode_n    = MODE_UNQUOTED;
          end
        end
        MODE_UNQUOTED: begin
          step_emit = 1'b1;
          if (is_blank || byte_i == ChrCr) begin
            step_kind = KIND_COMMIT;
            mode_n    = MODE_SKIP;
          end
        end
        MODE_QUOTED: begin
          if (byte_i == ChrQuote) begin
            step_emit = started_q;
            step_kind = KIND_COMMIT;
            started_d = 1'b0;
            mode_n    = MODE_SKIP;
          end else begin
            step_emit = 1'b1;
            started_d = 1'b1;
          end
        end
        default: mode_n = mode_q;
      endcase
    end

    // End of line, from a newline or from the final byte of the text.
    if (byte_i == ChrLf || last_i) begin
      if (byte_i == ChrLf) begin
        end_emit = (mode_q == MODE_UNQUOTED) || (mode_q == MODE_QUOTED);
        end_kind = (mode_q == MODE_QUOTED) ? KIND_DISCARD : KIND_COMMIT;
      end else begin
        end_emit = (mode_n == MODE_UNQUOTED) || (mode_n == MODE_QUOTED);
        end_kind = (mode_n == MODE_QUOTED) ? KIND_DISCARD : KIND_COMMIT;
      end
      mode_d    = MODE_LEAD;
      kw_idx_d  = 2'd0;
      started_d = 1'b0;
    end else begin
      mode_d = mode_n;
    end
  end

  always_comb begin
    res_o = '0;
    if (step_emit) begin
      res_o.res0.kind      = step_kind;
      res_o.res0.name_byte = (step_kind == KIND_BYTE) ? byte_i : 8'd0;
      if (end_emit) begin
        res_o.num           = 2'd2;
        res_o.res1.kind     = end_kind;
        res_o.res1.run_end  = 1'b1;
      end else begin
        res_o.num          = 2'd1;
        res_o.res0.run_end = 1'b1;
      end
    end else if (end_emit) begin
      res_o.num          = 2'd1;
      res_o.res0.kind    = end_kind;
      res_o.res0.run_end = 1'b1;
    end
  end

  `CSFRP_ASSERT_NXT(a_last_resets, fire_i && last_i, mode_q == MODE_LEAD && !started_q)
  `CSFRP_ASSERT_IMP(a_pair_shape, res_o.num == 2'd2, res_o.res0.kind == KIND_BYTE && res_o.res1.run_end)
  `CSFRP_ASSERT_NXT(a_hold_state, !fire_i, $stable(mode_q) && $stable(kw_idx_q) && $stable(started_q))

endmodule

>>> rtl/csfrp_out_fifo.sv
`include "cue_sheet_file_reference_parser_defines.svh"

module csfrp_out_fifo
  import csfrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t pair_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   head_o
);

  result_t    mem_q [FifoDepth];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] push_n;
  logic       pop;
  logic [1:0] wr_nxt;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(FifoDepth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign push_n  = push_i ? pair_i.num : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q <= 2'd1);
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = ptr_inc(wr_q);

  always_comb begin
    case (push_n)
      2'd1:    wr_d = wr_nxt;
      2'd2:    wr_d = ptr_inc(wr_nxt);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + push_n - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= pair_i.res0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_nxt] <= pair_i.res1;
    end
  end

  `CSFRP_ASSERT_IMP(a_no_overflow, push_n != 2'd0, cnt_q <= 2'd1)
  `CSFRP_ASSERT_NXT(a_pop_dec, pop && push_n == 2'd0, cnt_q == $past(cnt_q) - 2'd1)
  `CSFRP_ASSERT_NXT(a_push_inc, push_n == 2'd1 && !pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

>>> rtl/cue_sheet_file_reference_parser.sv
// Cue sheet FILE-line parser. Text enters one byte per word on the slave
// side (tlast marks the final byte of the text) and the file names of FILE
// lines leave on the master side as name bytes followed by a commit, or a
// discard for a quoted name left open at end of line; tuser carries the kind
// and tlast marks the last result word caused by an input byte. A byte passes
// an input register, is parsed combinationally and its zero to two results go
// into a three-entry output queue, so one byte is taken every cycle while the
// queue holds at most one entry; a byte that yields two results needs two
// output words, which sets the rate for such bytes.
module cue_sheet_file_reference_parser
  import csfrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_data
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] name_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o    // run_end
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       s_acc;
  logic       consume;
  logic       room;
  res_pair_t  pair;
  result_t    head;

  assign consume         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  csfrp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (consume),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (pair)
  );

  csfrp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (consume),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = head.name_byte;
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_end;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csfrp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 1050;
  localparam logic [31:0] KeywordText = "FILE";

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic       s_axis_tlast_i = 1'b0;   // end_of_data
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;          // [7:0] name_byte
  logic [1:0] m_axis_tuser_o;          // [1:0] kind
  logic       m_axis_tlast_o;          // run_end

  cue_sheet_file_reference_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // line parser shadow state
  mode_e       line_mode       = MODE_LEAD;
  logic [1:0]  kw_pos          = 2'd0;
  logic        quote_has_bytes = 1'b0;
  result_t     step_events[2];
  int          step_count;
  result_t     name_events_due[$];

  logic [7:0]  text_q[$];
  int unsigned burst_left    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned names_bytes   = 0;
  int unsigned names_commits = 0;
  int unsigned names_drops   = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_event(input kind_e k, input logic [7:0] b);
    step_events[step_count] = '{kind: k, name_byte: b, run_end: 1'b0};
    step_count++;
  endfunction

  function automatic void close_line();
    if (line_mode == MODE_UNQUOTED) begin
      push_event(KIND_COMMIT, 8'h00);
    end else if (line_mode == MODE_QUOTED) begin
      push_event(KIND_DISCARD, 8'h00);
    end
    line_mode       = MODE_LEAD;
    kw_pos          = 2'd0;
    quote_has_bytes = 1'b0;
  endfunction

  function automatic void parse_text_byte(input logic [7:0] b, input logic eod);
    logic    is_ws;
    result_t ev;
    is_ws      = (b == ChrSpace) || (b == ChrTab);
    step_count = 0;
    if (b == ChrLf) begin
      close_line();
    end else begin
      case (line_mode)
        MODE_LEAD: begin
          if (b == KeywordText[31:24]) begin
            line_mode = MODE_KEYWORD;
            kw_pos    = 2'd1;
          end else if (!(is_ws || b == ChrCr)) begin
            line_mode = MODE_SKIP;
          end
        end
        MODE_KEYWORD: begin
          if (b == KeywordText[8*(3-kw_pos) +: 8]) begin
            if (kw_pos == 2'd3) begin
              line_mode = MODE_GAP;
              kw_pos    = 2'd0;
            end else begin
              kw_pos = kw_pos + 2'd1;
            end
          end else begin
            line_mode = MODE_SKIP;
            kw_pos    = 2'd0;
          end
        end
        MODE_GAP: begin
          if (b == ChrQuote) begin
            line_mode       = MODE_QUOTED;
            quote_has_bytes = 1'b0;
          end else if (b == ChrCr) begin
            line_mode = MODE_SKIP;
          end else if (!is_ws) begin
            push_event(KIND_BYTE, b);
            line_mode = MODE_UNQUOTED;
          end
        end
        MODE_UNQUOTED: begin
          if (is_ws || b == ChrCr) begin
            push_event(KIND_COMMIT, 8'h00);
            line_mode = MODE_SKIP;
          end else begin
            push_event(KIND_BYTE, b);
          end
        end
        MODE_QUOTED: begin
          if (b == ChrQuote) begin
            if (quote_has_bytes) begin
              push_event(KIND_COMMIT, 8'h00);
            end
            quote_has_bytes = 1'b0;
            line_mode       = MODE_SKIP;
          end else begin
            push_event(KIND_BYTE, b);
            quote_has_bytes = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (eod) begin
        close_line();
      end
    end
    if (eod) begin
      line_mode       = MODE_LEAD;
      kw_pos          = 2'd0;
      quote_has_bytes = 1'b0;
    end
    for (int i = 0; i < step_count; i++) begin
      ev              = step_events[i];
      ev.run_end      = (i == step_count - 1);
      name_events_due = {name_events_due, ev};
    end
  endfunction

  // one text byte per word; bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eod;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_text_byte(b, eod);
    bytes_sent++;
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i]);
    end
  endfunction

  task automatic flush_text(input bit eod_last);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte(text_q[i], eod_last && (i == n - 1));
    end
    text_q.delete();
  endtask

  task automatic wait_for_names();
    s_axis_tvalid_i <= 1'b0;
    while (name_events_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_plain_names();
    add_text("FILE a.b\n");
    add_text("FILE \"x y\" WAVE\n");
    flush_text(1'b0);
  endtask

  task automatic test_leading_space_and_keyword();
    add_text(" \t\015FILE\tz\015\n");
    add_text("file q\nFIX q\nTRACK\n");
    flush_text(1'b0);
  endtask

  task automatic test_name_edge_cases();
    add_text("FILEx\nFILE \015\nFILE \"\"\nFILE \"ab\nFILE \"\n");
    add_text("FILE ");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    add_text("\nFILE \"\015\t");
    queue_byte(8'hFF);
    add_text("\"\n");
    flush_text(1'b0);
  endtask

  task automatic test_end_of_data();
    add_text("FILE ab");
    flush_text(1'b1);
    add_text("FILE \"c");
    flush_text(1'b1);
    add_text("FILE \"d\"");
    flush_text(1'b1);
    add_text("FILE e\n");
    flush_text(1'b1);
    add_text("F");
    flush_text(1'b1);
    add_text("ILE g\n");
    flush_text(1'b0);
  endtask

  // stop mid-name until the output side is empty, then finish the line
  task automatic test_drain_pause();
    add_text("FILE p");
    flush_text(1'b0);
    wait_for_names();
    add_text("q r\n");
    flush_text(1'b0);
  endtask

  task automatic test_random_text();
    int unsigned start, pick, n, cut;
    logic [7:0]  b;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0:       queue_byte(ChrSpace);
            1:       queue_byte(ChrTab);
            default: queue_byte(ChrCr);
          endcase
        end
        if (pick < 88) begin
          add_text("FILE");
        end else begin
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) queue_byte(KeywordText[8*(3-i) +: 8]);
          queue_byte(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) queue_byte($urandom_range(0, 1) ? ChrSpace : ChrTab);
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        if ($urandom_range(0, 1)) begin
          queue_byte(ChrQuote);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == ChrQuote || b == ChrLf);
            queue_byte(b);
          end
          if ($urandom_range(0, 6) != 0) queue_byte(ChrQuote);
        end else begin
          if (n == 0 && $urandom_range(0, 1)) queue_byte(ChrCr);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255));
            while (b == ChrSpace || b == ChrTab || b == ChrCr || b == ChrLf);
            queue_byte(b);
          end
        end
        if ($urandom_range(0, 1)) add_text(" WAVE");
        if ($urandom_range(0, 3) == 0) queue_byte(ChrCr);
      end
      case ($urandom_range(0, 19))
        0: flush_text(1'b1);
        1: begin
          queue_byte(ChrLf);
          flush_text(1'b1);
        end
        2: begin
          cut = $urandom_range(1, text_q.size());
          while (text_q.size() > cut) void'(text_q.pop_back());
          flush_text(1'b1);
        end
        default: begin
          queue_byte(ChrLf);
          flush_text(1'b0);
        end
      endcase
    end
  endtask

  initial begin : ready_pattern
    int unsigned style, span;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk_i);
        case (style)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_names
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (name_events_due.size() == 0) begin
        $error("unexpected word: kind %0d, name_byte %02h, run_end %0b",
               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = name_events_due.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o !== want.name_byte) begin
          $error("name_byte: expected %02h, got %02h", want.name_byte, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast_o);
          mismatches++;
        end
        case (want.kind)
          KIND_BYTE:   names_bytes++;
          KIND_COMMIT: names_commits++;
          default:     names_drops++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still due",
               cycle_count, name_events_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_names();
    test_leading_space_and_keyword();
    test_name_edge_cases();
    test_end_of_data();
    test_drain_pause();
    test_random_text();
    wait_for_names();
    repeat (8) @(posedge clk_i);
    $display("Parsed %0d text bytes of FILE lines, noise and cut-off texts;", bytes_sent);
    $display("checked %0d name bytes, %0d commits, %0d discards.",
             names_bytes, names_commits, names_drops);
    if (mismatches == 0 && name_events_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/csfrp_pkg.sv
rtl/csfrp_parse.sv
rtl/csfrp_out_fifo.sv
rtl/cue_sheet_file_reference_parser.sv
test/tb_top.sv
